/* design/pat_pkg.sv */
// pat_pkg: shared types, character codes and mnemonic tables for the
// plc address text parser. No dependencies; used by the channel interfaces
// and the top level.
package pat_pkg;

   // payload widths of the two channels and the mnemonic count
   localparam int CHAR_W = 8;
   localparam int FIELD_W = 16;
   localparam int SIZE_W = 3;
   localparam int NUM_MNEM = 7;

   // where the next digit goes
   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_FILE = 2'd1,
      TGT_ELEMENT = 2'd2,
      TGT_SUB = 2'd3
   } digit_target_type;

   // characters with a meaning of their own
   localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CASE_OFFSET = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_O = 8'h4F;
   localparam logic [CHAR_W-1:0] CHAR_I = 8'h49;
   localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_B = 8'h42;
   localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_R = 8'h52;
   localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
   localparam logic [CHAR_W-1:0] CHAR_F = 8'h46;

   // file type codes
   localparam logic [7:0] FTYPE_O = 8'h8b;
   localparam logic [7:0] FTYPE_I = 8'h8c;
   localparam logic [7:0] FTYPE_S = 8'h84;
   localparam logic [7:0] FTYPE_B = 8'h85;
   localparam logic [7:0] FTYPE_T = 8'h86;
   localparam logic [7:0] FTYPE_C = 8'h87;
   localparam logic [7:0] FTYPE_R = 8'h88;
   localparam logic [7:0] FTYPE_N = 8'h89;
   localparam logic [7:0] FTYPE_F = 8'h8a;

   localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd2;
   localparam logic [SIZE_W-1:0] SIZE_FLOAT = 3'd4;

   // decoded file letter
   typedef struct packed {
      logic hit;
      logic [7:0] ftype;
      logic [SIZE_W-1:0] size;
      logic fixed_one;
      logic has_number;
   } file_info_type;

   // sub-element mnemonics: acc pre len pos en tt dn, later entries win
   localparam logic [CHAR_W-1:0] MNEM_TEXT [0:NUM_MNEM-1][0:3] = '{
      '{"a", "c", "c", 8'h00},
      '{"p", "r", "e", 8'h00},
      '{"l", "e", "n", 8'h00},
      '{"p", "o", "s", 8'h00},
      '{"e", "n", 8'h00, 8'h00},
      '{"t", "t", 8'h00, 8'h00},
      '{"d", "n", 8'h00, 8'h00}
   };
   localparam logic [1:0] MNEM_LEN [0:NUM_MNEM-1] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2};
   localparam logic [3:0] MNEM_CODE [0:NUM_MNEM-1] =
      '{4'd2, 4'd1, 4'd1, 4'd2, 4'd13, 4'd14, 4'd15};

   // file letter decode
   function automatic file_info_type decode_letter(input logic [CHAR_W-1:0] c);
      file_info_type info;
      info = '0;
      info.hit = 1'b1;
      info.size = SIZE_WORD;
      info.has_number = 1'b1;
      case (c)
         CHAR_O: begin
            info.ftype = FTYPE_O;
            info.has_number = 1'b0;
         end
         CHAR_I: begin
            info.ftype = FTYPE_I;
            info.fixed_one = 1'b1;
            info.has_number = 1'b0;
         end
         CHAR_S: info.ftype = FTYPE_S;
         CHAR_B: info.ftype = FTYPE_B;
         CHAR_T: info.ftype = FTYPE_T;
         CHAR_C: info.ftype = FTYPE_C;
         CHAR_R: info.ftype = FTYPE_R;
         CHAR_N: info.ftype = FTYPE_N;
         CHAR_F: begin
            info.ftype = FTYPE_F;
            info.size = SIZE_FLOAT;
         end
         default: info = '0;
      endcase
      return info;
   endfunction

endpackage

/* design/pat_req_if.sv */
// pat_req_if: character channel into the address parser.
// Depends on pat_pkg for the character width.
interface pat_req_if;
   logic valid;
   logic ready;
   logic [pat_pkg::CHAR_W-1:0] char_code;
   logic is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink (input valid, input char_code, input is_last, output ready);
endinterface

/* design/pat_rsp_if.sv */
// pat_rsp_if: parsed address channel out of the address parser.
// Depends on pat_pkg for the field widths.
interface pat_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] letter_code;
   logic [7:0] type_code;
   logic [pat_pkg::FIELD_W-1:0] file_index;
   logic [pat_pkg::FIELD_W-1:0] element_index;
   logic [pat_pkg::FIELD_W-1:0] sub_index;
   logic [pat_pkg::SIZE_W-1:0] element_size;

   modport source (output valid, output letter_code, output type_code, output file_index,
                   output element_index, output sub_index, output element_size,
                   input ready);
   modport sink (input valid, input letter_code, input type_code, input file_index,
                 input element_index, input sub_index, input element_size,
                 output ready);
endinterface

/* design/plc_address_text_parser.sv */
// plc_address_text_parser: top level, parses a plc address one character per transfer.
// Depends on pat_pkg, pat_req_if and pat_rsp_if.
// Throughput: one character per cycle; the parse state updates in the cycle of the transfer.
// The result appears in the output register in the cycle after the last character.
// A result that the result side has not taken holds off further characters until it goes.
// Reset (synchronous): parse state returns to empty, no result pending.
module plc_address_text_parser #(
   parameter int NUMBER_BITS = 16
) (
   input logic clock,
   input logic reset,
   pat_req_if.sink req,
   pat_rsp_if.source rsp
);

   localparam int ACC_W = NUMBER_BITS + 5;

   // parse state
   logic in_sub_ff, in_sub_in;
   pat_pkg::digit_target_type target_ff, target_in;
   logic [7:0] letter_ff, letter_in;
   logic [7:0] ftype_ff, ftype_in;
   logic [NUMBER_BITS-1:0] file_ff, file_in;
   logic [pat_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [NUMBER_BITS-1:0] element_ff, element_in;
   logic [NUMBER_BITS-1:0] sub_ff, sub_in;
   logic [pat_pkg::NUM_MNEM-1:0] hits_ff, hits_in;
   logic [2:0] rest_ff, rest_in;

   // output register
   logic rsp_valid_ff;
   logic [7:0] rsp_letter_ff;
   logic [7:0] rsp_ftype_ff;
   logic [pat_pkg::FIELD_W-1:0] rsp_file_ff;
   logic [pat_pkg::FIELD_W-1:0] rsp_element_ff;
   logic [pat_pkg::FIELD_W-1:0] rsp_sub_ff;
   logic [pat_pkg::SIZE_W-1:0] rsp_size_ff;

   logic accept;
   logic is_digit;
   logic [pat_pkg::CHAR_W-1:0] lower_char;
   pat_pkg::file_info_type finfo;
   logic [NUMBER_BITS-1:0] sub_final;

   // decimal accumulate with saturation
   function automatic logic [NUMBER_BITS-1:0] add_digit(input logic [NUMBER_BITS-1:0] v,
                                                         input logic [3:0] d);
      logic [ACC_W-1:0] r;
      r = (ACC_W'(v) << 3) + (ACC_W'(v) << 1) + ACC_W'(d);
      return (r[ACC_W-1:NUMBER_BITS] != '0) ? '1 : r[NUMBER_BITS-1:0];
   endfunction

   assign accept = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;

   assign is_digit = (req.char_code >= pat_pkg::CHAR_0) && (req.char_code <= pat_pkg::CHAR_9);
   assign lower_char = ((req.char_code >= pat_pkg::CHAR_UPPER_A) &&
                        (req.char_code <= pat_pkg::CHAR_UPPER_Z)) ?
                       req.char_code + pat_pkg::CHAR_CASE_OFFSET : req.char_code;
   assign finfo = pat_pkg::decode_letter(req.char_code);

   // one character step
   always_comb begin
      in_sub_in = in_sub_ff;
      target_in = target_ff;
      letter_in = letter_ff;
      ftype_in = ftype_ff;
      file_in = file_ff;
      size_in = size_ff;
      element_in = element_ff;
      sub_in = sub_ff;
      hits_in = hits_ff;
      rest_in = rest_ff;
      if (in_sub_ff) begin
         if (is_digit && (rest_ff == 3'd0 || target_ff == pat_pkg::TGT_SUB)) begin
            target_in = pat_pkg::TGT_SUB;
            sub_in = add_digit(sub_ff, req.char_code[3:0]);
         end else begin
            target_in = pat_pkg::TGT_NONE;
         end
         for (int i = 0; i < pat_pkg::NUM_MNEM; i++) begin
            if (rest_ff >= 3'(pat_pkg::MNEM_LEN[i]) ||
                lower_char != pat_pkg::MNEM_TEXT[i][rest_ff[1:0]]) begin
               hits_in[i] = 1'b0;
            end
         end
         rest_in = (rest_ff != 3'd7) ? rest_ff + 3'd1 : rest_ff;
      end else if (is_digit && target_ff == pat_pkg::TGT_FILE) begin
         file_in = add_digit(file_ff, req.char_code[3:0]);
      end else if (is_digit && target_ff == pat_pkg::TGT_ELEMENT) begin
         element_in = add_digit(element_ff, req.char_code[3:0]);
      end else begin
         target_in = pat_pkg::TGT_NONE;
         if (finfo.hit) begin
            letter_in = req.char_code;
            ftype_in = finfo.ftype;
            size_in = finfo.size;
            file_in = NUMBER_BITS'(finfo.fixed_one);
            target_in = finfo.has_number ? pat_pkg::TGT_FILE : pat_pkg::TGT_NONE;
         end else if (req.char_code == pat_pkg::CHAR_COLON) begin
            element_in = '0;
            target_in = pat_pkg::TGT_ELEMENT;
         end else if (req.char_code == pat_pkg::CHAR_SLASH ||
                      req.char_code == pat_pkg::CHAR_DOT) begin
            in_sub_in = 1'b1;
            hits_in = '1;
            rest_in = 3'd0;
         end
      end
   end

   // mnemonic resolve on the last character, later table entries win
   always_comb begin
      sub_final = sub_in;
      if (in_sub_in && rest_in != 3'd0) begin
         for (int i = 0; i < pat_pkg::NUM_MNEM; i++) begin
            if (hits_in[i]) begin
               sub_final = NUMBER_BITS'(pat_pkg::MNEM_CODE[i]);
            end
         end
      end
   end

   // parse state registers, cleared after the last character
   always_ff @(posedge clock) begin
      if (reset || (accept && req.is_last)) begin
         in_sub_ff <= 1'b0;
         target_ff <= pat_pkg::TGT_NONE;
         letter_ff <= '0;
         ftype_ff <= '0;
         file_ff <= '0;
         size_ff <= '0;
         element_ff <= '0;
         sub_ff <= '0;
         hits_ff <= '1;
         rest_ff <= 3'd0;
      end else if (accept) begin
         in_sub_ff <= in_sub_in;
         target_ff <= target_in;
         letter_ff <= letter_in;
         ftype_ff <= ftype_in;
         file_ff <= file_in;
         size_ff <= size_in;
         element_ff <= element_in;
         sub_ff <= sub_in;
         hits_ff <= hits_in;
         rest_ff <= rest_in;
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req.is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (accept && req.is_last) begin
         rsp_letter_ff <= letter_in;
         rsp_ftype_ff <= ftype_in;
         rsp_file_ff <= pat_pkg::FIELD_W'(file_in);
         rsp_element_ff <= pat_pkg::FIELD_W'(element_in);
         rsp_sub_ff <= pat_pkg::FIELD_W'(sub_final);
         rsp_size_ff <= size_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.letter_code = rsp_letter_ff;
   assign rsp.type_code = rsp_ftype_ff;
   assign rsp.file_index = rsp_file_ff;
   assign rsp.element_index = rsp_element_ff;
   assign rsp.sub_index = rsp_sub_ff;
   assign rsp.element_size = rsp_size_ff;

   // last character always produces a pending result
   assert property (@(posedge clock) disable iff (reset)
      accept && req.is_last |=> rsp_valid_ff)
      else $error("last character transfer did not load a result");

   // state is empty after the last character
   assert property (@(posedge clock) disable iff (reset)
      accept && req.is_last |=> !in_sub_ff && target_ff == pat_pkg::TGT_NONE &&
                                rest_ff == 3'd0 && hits_ff == '1)
      else $error("parse state not cleared after last character");

   // sub text length only grows inside the sub-element phase
   assert property (@(posedge clock) disable iff (reset)
      !in_sub_ff |-> rest_ff == 3'd0)
      else $error("sub text length nonzero outside sub phase");

   // sub-element digits only inside the sub-element phase
   assert property (@(posedge clock) disable iff (reset)
      target_ff == pat_pkg::TGT_SUB |-> in_sub_ff)
      else $error("sub-element digit target outside sub phase");

   // a waiting result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("transfer taken while result stalled");

endmodule
